/* hw/rtl/mau_pkg.sv */
// Shared constants, types and codes for the modular arithmetic unit.
package mau_pkg;

    localparam int MOD_BITS_DEF = 31;
    localparam logic [30:0] MOD_RESET = 31'd998244353;
    localparam int OPD_W = 64;
    localparam int RES_W = 31;
    localparam int ACT_W = 3;
    localparam int IN_TDATA_W = 2 * OPD_W;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [ACT_W-1:0] {
        ACT_REDUCE = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_SUB    = 3'd2,
        ACT_MUL    = 3'd3,
        ACT_DIV    = 3'd4,
        ACT_NEG    = 3'd5,
        ACT_CMP    = 3'd6
    } t_action;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_core_req;

endpackage

/* hw/rtl/mau_reduce.sv */
// Bit-serial reduction of a signed 64-bit operand into 0 .. m-1.
module mau_reduce #(
    parameter int MB = mau_pkg::MOD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mau_pkg::OPD_W-1:0]  i_value,
    input  logic [MB-1:0]              i_m,
    output logic                       o_done,
    output logic [MB-1:0]              o_res
);

    localparam int CW = $clog2(mau_pkg::OPD_W);

    logic                      r_busy;
    logic                      r_done;
    logic                      r_neg;
    logic [CW-1:0]             r_cnt;
    logic [mau_pkg::OPD_W-1:0] r_sh;
    logic [MB-1:0]             r_r;
    logic [MB:0]               n_t;
    logic [MB-1:0]             n_r;

    // shift in one magnitude bit, one compare-subtract keeps r below m
    always_comb begin
        n_t = {r_r, r_sh[mau_pkg::OPD_W-1]};
        if (n_t >= {1'b0, i_m}) begin
            n_t = n_t - {1'b0, i_m};
        end
        n_r = n_t[MB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_value[mau_pkg::OPD_W-1];
                r_sh   <= i_value[mau_pkg::OPD_W-1] ? (~i_value + 1'b1) : i_value;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r   <= n_r;
                r_sh  <= {r_sh[mau_pkg::OPD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(mau_pkg::OPD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // negative values wrap upward
    assign o_done = r_done;
    assign o_res  = (r_neg && (r_r != '0)) ? (i_m - r_r) : r_r;

endmodule

/* hw/rtl/mau_core.sv */
// Serial modular multiply and extended Euclid inverse sequencer.
module mau_core #(
    parameter int MB = mau_pkg::MOD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mau_pkg::t_core_req i_req,
    input  logic [MB-1:0]      i_a,
    input  logic [MB-1:0]      i_b,
    input  logic [MB-1:0]      i_m,
    output logic               o_done,
    output logic [MB-1:0]      o_res,
    output logic               o_ninv
);

    localparam int CW = (MB > 1) ? $clog2(MB) : 1;

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_CHECK = 5'b00010,
        C_DIV   = 5'b00100,
        C_UPD   = 5'b01000,
        C_MUL   = 5'b10000
    } t_cstate;

    t_cstate       r_state;
    logic          r_done;
    logic          r_ninv;
    logic [CW-1:0] r_cnt;
    logic [MB-1:0] r_ea, r_eb, r_x, r_u, r_rem, r_q, r_acc, r_ma, r_mb;

    logic          n_ge;
    logic [MB:0]   n_t;
    logic [MB-1:0] n_rem;
    logic          n_bit;
    logic [MB-1:0] n_add;
    logic [MB:0]   n_dbl;
    logic [MB:0]   n_sum;
    logic [MB-1:0] n_acc;
    logic [MB:0]   n_diff;
    logic          n_last;

    always_comb begin
        // one restoring division step of eb by ea
        n_t   = {r_rem, r_q[MB-1]};
        n_ge  = (n_t >= {1'b0, r_ea});
        n_t   = n_ge ? (n_t - {1'b0, r_ea}) : n_t;
        n_rem = n_t[MB-1:0];

        // Horner step: acc = 2*acc + bit*addend, mod m
        n_bit = (r_state == C_DIV) ? n_ge : r_mb[MB-1];
        n_add = (r_state == C_DIV) ? r_u : r_ma;
        n_dbl = {r_acc, 1'b0};
        if (n_dbl >= {1'b0, i_m}) begin
            n_dbl = n_dbl - {1'b0, i_m};
        end
        n_sum = {1'b0, n_dbl[MB-1:0]} + (n_bit ? {1'b0, n_add} : '0);
        if (n_sum >= {1'b0, i_m}) begin
            n_sum = n_sum - {1'b0, i_m};
        end
        n_acc = n_sum[MB-1:0];

        // new coefficient u = x - q*u, mod m
        n_diff = (r_x >= r_acc) ? ({1'b0, r_x} - {1'b0, r_acc})
                                : ({1'b0, r_x} + {1'b0, i_m} - {1'b0, r_acc});
        n_last = (r_cnt == CW'(MB - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_ma  <= i_a;
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (i_req.is_div) begin
                            r_ea    <= i_b;
                            r_eb    <= i_m;
                            r_x     <= '0;
                            r_u     <= MB'(1);
                            r_state <= C_CHECK;
                        end else begin
                            r_ninv  <= 1'b0;
                            r_mb    <= i_b;
                            r_state <= C_MUL;
                        end
                    end
                end
                C_CHECK: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (r_ea == '0) begin
                        // gcd found in eb; multiply a by the coefficient
                        r_ninv  <= (r_eb != MB'(1));
                        r_mb    <= r_x;
                        r_state <= C_MUL;
                    end else begin
                        r_rem   <= '0;
                        r_q     <= r_eb;
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[MB-2:0], 1'b0};
                    r_acc <= n_acc;
                    r_cnt <= r_cnt + 1'b1;
                    if (n_last) begin
                        r_state <= C_UPD;
                    end
                end
                C_UPD: begin
                    r_x     <= r_u;
                    r_u     <= n_diff[MB-1:0];
                    r_eb    <= r_ea;
                    r_ea    <= r_rem;
                    r_state <= C_CHECK;
                end
                C_MUL: begin
                    r_acc <= n_acc;
                    r_mb  <= {r_mb[MB-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (n_last) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
    assign o_ninv = r_ninv;

endmodule

/* hw/rtl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: config register, control and result staging.
//
//  channel   | direction | handshake                | contents
//  s_axis    | in        | tvalid/tready            | tdata: a, b; tuser: action
//  m_axis    | out       | tvalid/tready            | tdata: residue, equal, not_invertible
//  apb       | in        | psel/penable/pwrite      | register 0: modulus
//
// Both operands are reduced in parallel, one bit per cycle. Reduce, add, subtract,
// negate and compare then take their result straight from the reduced operands.
// Multiply then runs in the shared Horner unit. Divide runs Euclid steps, each a
// division and an update, then a final check and multiply. Reset is synchronous,
// active low; the modulus resets to 998244353.
// One item is in flight at a time; a new item is taken while a finished result
// still waits in the output register.
module modular_arithmetic_unit #(
    parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // [63:0] operand_a, [127:64] operand_b
    input  logic [mau_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] action
    input  logic [mau_pkg::ACT_W-1:0]       s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [30:0] residue, [31] equal, [32] not_invertible, [39:33] zero
    output logic [mau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int MB = MOD_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RED  = 4'b0010,
        S_CORE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state;
    logic [MB-1:0]      r_modulus;
    mau_pkg::t_action   r_action;
    logic [MB-1:0]      r_res;
    logic               r_eq;
    logic               r_ninv;
    logic               r_ovalid;
    logic [MB-1:0]      r_ores;
    logic               r_oeq;
    logic               r_oninv;

    logic               in_xfer;
    logic [MB-1:0]      m_eff;
    logic               red_a_done, red_b_done;
    logic [MB-1:0]      red_a, red_b;
    mau_pkg::t_core_req core_req;
    logic               core_done;
    logic [MB-1:0]      core_res;
    logic               core_ninv;
    logic [MB:0]        n_sum;
    logic [MB-1:0]      n_simple;
    logic               n_eq;

    // config: one register, written at byte addresses 0 to 3 (paddr[2] low)
    assign pready = 1'b1;
    assign prdata = 32'(r_modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MB'(mau_pkg::MOD_RESET);
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_modulus <= pwdata[MB-1:0];
        end
    end

    // a modulus below two acts as one
    assign m_eff = (r_modulus < MB'(2)) ? MB'(1) : r_modulus;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    mau_reduce #(.MB(MB)) u_red_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_value (s_axis_tdata[mau_pkg::OPD_W-1:0]),
        .i_m     (m_eff),
        .o_done  (red_a_done),
        .o_res   (red_a)
    );

    mau_reduce #(.MB(MB)) u_red_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_value (s_axis_tdata[mau_pkg::IN_TDATA_W-1:mau_pkg::OPD_W]),
        .i_m     (m_eff),
        .o_done  (red_b_done),
        .o_res   (red_b)
    );

    always_comb begin
        core_req.start  = (r_state == S_RED) && red_a_done &&
                          ((r_action == mau_pkg::ACT_MUL) || (r_action == mau_pkg::ACT_DIV));
        core_req.is_div = (r_action == mau_pkg::ACT_DIV);
    end

    mau_core #(.MB(MB)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .i_a     (red_a),
        .i_b     (red_b),
        .i_m     (m_eff),
        .o_done  (core_done),
        .o_res   (core_res),
        .o_ninv  (core_ninv)
    );

    // combinational actions on the reduced operands
    always_comb begin
        n_simple = '0;
        n_eq     = 1'b0;
        n_sum    = '0;
        case (r_action)
            mau_pkg::ACT_REDUCE: begin
                n_simple = red_a;
            end
            mau_pkg::ACT_ADD: begin
                n_sum = {1'b0, red_a} + {1'b0, red_b};
                if (n_sum >= {1'b0, m_eff}) begin
                    n_sum = n_sum - {1'b0, m_eff};
                end
                n_simple = n_sum[MB-1:0];
            end
            mau_pkg::ACT_SUB: begin
                n_sum = (red_a >= red_b) ? ({1'b0, red_a} - {1'b0, red_b})
                                         : ({1'b0, red_a} + {1'b0, m_eff} - {1'b0, red_b});
                n_simple = n_sum[MB-1:0];
            end
            mau_pkg::ACT_NEG: begin
                n_simple = (red_a == '0) ? '0 : (m_eff - red_a);
            end
            mau_pkg::ACT_CMP: begin
                n_eq = (red_a == red_b);
            end
            default: begin
                n_simple = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output once taken, unless a new result reloads it
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_action <= mau_pkg::t_action'(s_axis_tuser);
                        r_state  <= S_RED;
                    end
                end
                S_RED: begin
                    if (red_a_done && red_b_done) begin
                        if (core_req.start) begin
                            r_state <= S_CORE;
                        end else begin
                            r_res   <= n_simple;
                            r_eq    <= n_eq;
                            r_ninv  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CORE: begin
                    if (core_done) begin
                        r_res   <= core_res;
                        r_eq    <= 1'b0;
                        r_ninv  <= core_ninv;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ores   <= r_res;
                        r_oeq    <= r_eq;
                        r_oninv  <= r_ninv;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_oninv, r_oeq, mau_pkg::RES_W'(r_ores)};

endmodule

/* test/modular_arithmetic_unit_tb.sv */
// Testbench for the modular arithmetic unit: directed and random operations over several moduli.
module modular_arithmetic_unit_tb;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic [mau_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [mau_pkg::ACT_W-1:0]       s_axis_tuser = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [mau_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    typedef struct packed {
        logic [30:0] residue;
        logic        equal;
        logic        not_invertible;
    } t_mod_result;

    t_mod_result     pending_results[$];
    logic [30:0]     cur_modulus;
    int              n_errors = 0;
    longint unsigned cycle_count = 0;

    // Generous bound on the run for about 2000 items, worst case included.
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    modular_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Wrap a signed operand into 0 .. m-1.
    function automatic logic [63:0] wrap_operand(logic [63:0] raw, logic [63:0] m);
        logic [63:0] r;
        if (!raw[63]) return raw % m;
        r = (64'd0 - raw) % m;
        return (r == 0) ? 64'd0 : m - r;
    endfunction

    // Extended Euclid: Bezout coefficient of n mod m, gcd out.
    function automatic logic [63:0] bezout_coeff(logic [63:0] n, logic [63:0] m,
                                                 output logic [63:0] g);
        longint x, u, a, b, q, t;
        x = 0; u = 1; a = n; b = m;
        while (a != 0) begin
            q = b / a;
            t = x - q * u; x = u; u = t;
            t = b - q * a; b = a; a = t;
        end
        g = b;
        x = x % longint'(m);
        if (x < 0) x = x + longint'(m);
        return x;
    endfunction

    function automatic t_mod_result mod_compute(logic [2:0] act, logic [63:0] ra,
                                                logic [63:0] rb);
        t_mod_result r;
        logic [63:0] m, a, b, s, g, inv;
        m = (cur_modulus < 2) ? 64'd1 : {33'd0, cur_modulus};
        a = wrap_operand(ra, m);
        b = wrap_operand(rb, m);
        r = '0;
        s = '0;
        g = 64'd1;
        case (act)
            mau_pkg::ACT_REDUCE: s = a;
            mau_pkg::ACT_ADD:    begin s = a + b; if (s >= m) s = s - m; end
            mau_pkg::ACT_SUB:    s = (a >= b) ? a - b : a + m - b;
            mau_pkg::ACT_MUL:    s = (a * b) % m;
            mau_pkg::ACT_DIV: begin
                inv = bezout_coeff(b, m, g);
                s = (a * inv) % m;
                r.not_invertible = (g != 64'd1);
            end
            mau_pkg::ACT_NEG:    s = (a == 0) ? 64'd0 : m - a;
            mau_pkg::ACT_CMP:    r.equal = (a == b);
            default:             s = '0;
        endcase
        r.residue = s[30:0];
        return r;
    endfunction

    // Drive one operation; wait a random gap first and hold until the transfer.
    task automatic send_op(logic [2:0] act, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        pending_results.push_back(mod_compute(act, a, b));
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Downstream stall: draw a fresh ready pattern per result.
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_mod_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.residue        = m_axis_tdata[30:0];
            got.equal          = m_axis_tdata[31];
            got.not_invertible = m_axis_tdata[32];
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.residue !== want.residue) begin
                    $error("residue exp %0d got %0d", want.residue, got.residue);
                    n_errors++;
                end
                if (got.equal !== want.equal) begin
                    $error("equal exp %0d got %0d", want.equal, got.equal);
                    n_errors++;
                end
                if (got.not_invertible !== want.not_invertible) begin
                    $error("not_invertible exp %0d got %0d",
                           want.not_invertible, got.not_invertible);
                    n_errors++;
                end
            end
        end
    end

    // Drop the input and wait until every prediction is matched.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write the modulus over APB; only with the unit idle.
    task automatic set_modulus(logic [30:0] m);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= '0; pwdata <= {1'b0, m};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_modulus = m;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand mix: small, near multiples of the modulus, extremes, full random.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 20));
            1: return -longint'($urandom_range(0, 20));
            2: return {33'd0, cur_modulus} * 64'($urandom_range(0, 3))
                      + 64'($urandom_range(0, 2)) - 64'd1;
            3: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                            : 64'h7FFF_FFFF_FFFF_FFFF;
            default: return rand64();
        endcase
    endfunction

    task automatic test_directed_ops();
        logic [63:0] mx, mn;
        mx = 64'h7FFF_FFFF_FFFF_FFFF;
        mn = 64'h8000_0000_0000_0000;
        send_op(mau_pkg::ACT_REDUCE, mx, 64'd0);
        send_op(mau_pkg::ACT_REDUCE, mn, 64'd0);
        send_op(mau_pkg::ACT_REDUCE, -64'd1, 64'd0);
        send_op(mau_pkg::ACT_ADD, mx, mx);
        send_op(mau_pkg::ACT_ADD, -64'd1, -64'd1);
        send_op(mau_pkg::ACT_SUB, 64'd0, 64'd1);
        send_op(mau_pkg::ACT_SUB, mn, mx);
        send_op(mau_pkg::ACT_MUL, -64'd1, -64'd1);
        send_op(mau_pkg::ACT_MUL, mx, mn);
        send_op(mau_pkg::ACT_DIV, 64'd6, 64'd3);
        send_op(mau_pkg::ACT_DIV, 64'd5, 64'd0);
        send_op(mau_pkg::ACT_DIV, 64'd7, {33'd0, cur_modulus});
        send_op(mau_pkg::ACT_DIV, -64'd1, -64'd1);
        send_op(mau_pkg::ACT_NEG, 64'd0, 64'd0);
        send_op(mau_pkg::ACT_NEG, 64'd1, 64'd0);
        send_op(mau_pkg::ACT_CMP, -64'd1, {33'd0, cur_modulus} - 64'd1);
        send_op(mau_pkg::ACT_CMP, 64'd1, 64'd2);
        send_op(3'd7, mx, mx);
    endtask

    task automatic test_shared_factor();
        // Composite modulus so divisors sharing a factor occur.
        set_modulus(31'd360);
        send_op(mau_pkg::ACT_DIV, 64'd7, 64'd12);
        send_op(mau_pkg::ACT_DIV, 64'd11, 64'd7);
        send_op(mau_pkg::ACT_DIV, -64'd5, 64'd180);
    endtask

    task automatic test_random_ops(int n);
        repeat (n) send_op(3'($urandom_range(0, 7)), pick_operand(), pick_operand());
    endtask

    initial begin
        cur_modulus = mau_pkg::MOD_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_ops();
        test_shared_factor();
        // Sweep moduli, the extremes included.
        set_modulus(31'd2);
        test_random_ops(200);
        set_modulus(31'h7FFF_FFFF);
        test_random_ops(400);
        set_modulus(31'd998244353);
        test_random_ops(400);
        set_modulus(31'd1);
        test_random_ops(100);
        set_modulus(31'd0);
        test_random_ops(100);
        set_modulus(31'd1_000_000);
        test_random_ops(300);
        set_modulus(31'($urandom()));
        test_random_ops(400);
        drain();
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
